// ===== rtl/somr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// somr_pkg
// Shared types, codes and default sizes for the spiral order matrix reader.
// ----------------------------------------------------------------------------
package somr_pkg;

    // Default store geometry and element width
    localparam int MAX_ROWS_DEF     = 16;
    localparam int MAX_COLS_DEF     = 16;
    localparam int ELEMENT_BITS_DEF = 16;

    // Fixed field widths of the request and result ports
    localparam int POS_BITS   = 4;
    localparam int VALUE_BITS = 16;
    localparam int CFG_BITS   = 5;
    localparam int IDX_BITS   = 1;

    // Matrix size after reset
    localparam int SIZE_RESET = 3;

    // Configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_ROWS = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_COLS = 1'b1;

    // Request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_NEXT = 1'b1;

    // Walk direction, counter-clockwise from the top-left corner
    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_LEFT  = 2'd3
    } somr_dir_t;

    // Commands from the top level to the walk unit
    typedef struct packed {
        logic advance;
        logic restart;
    } somr_walk_cmd_t;

endpackage : somr_pkg
`default_nettype wire

// ===== rtl/spiral_order_matrix_reader.sv =====
`default_nettype none
// A next request's result shows in the cycle after the request is taken.
// Throughput: one request per cycle, loads and nexts alike; busy stays low.
// The walk step is one combinational pass over at most four turns, and the
// element comes from the store's registered read port in the next cycle.
// Reset: size 3x3, walk at its start; the store holds nothing until loaded.
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader
// Matrix store read back in counter-clockwise spiral order, one element
// per next request, with position and a last flag.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader
    import somr_pkg::*;
#(
    parameter int MAX_ROWS     = MAX_ROWS_DEF,
    parameter int MAX_COLS     = MAX_COLS_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         kind,
    input  wire logic        [POS_BITS-1:0]   row,
    input  wire logic        [POS_BITS-1:0]   col,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire logic                         wr_en,
    input  wire logic        [IDX_BITS-1:0]   wr_index,
    input  wire logic        [CFG_BITS-1:0]   wr_data,
    output logic                              done,
    output logic signed      [VALUE_BITS-1:0] element,
    output logic             [POS_BITS-1:0]   at_row,
    output logic             [POS_BITS-1:0]   at_col,
    output logic                              last
);

    localparam int RSW   = $clog2(MAX_ROWS + 1);
    localparam int CSW   = $clog2(MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROWS_RST = (SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET;
    localparam int COLS_RST = (SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET;

    logic [RSW-1:0]          rows_reg, rows_next;
    logic [CSW-1:0]          cols_reg, cols_next;
    logic                    done_reg;
    logic [POS_BITS-1:0]     at_row_reg;
    logic [POS_BITS-1:0]     at_col_reg;
    logic                    last_reg;

    logic                    accept;
    logic                    load_req;
    logic                    next_req;
    logic                    store_we;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic [ELEMENT_BITS-1:0] store_wdata;
    logic [ELEMENT_BITS-1:0] store_rdata;
    somr_walk_cmd_t          walk_cmd;
    logic [RSW-1:0]          step_row;
    logic [CSW-1:0]          step_col;
    logic                    step_last;

    // Every request is taken at once
    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign load_req = accept && (kind == KIND_LOAD);
    assign next_req = accept && (kind == KIND_NEXT);

    // Clamp size writes into 1..max
    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (wr_en && (wr_index == REG_ROWS))
        begin
            if (wr_data == '0)
                rows_next = RSW'(1);
            else if (32'(wr_data) > MAX_ROWS)
                rows_next = RSW'(MAX_ROWS);
            else
                rows_next = RSW'(wr_data);
        end
        if (wr_en && (wr_index == REG_COLS))
        begin
            if (wr_data == '0)
                cols_next = CSW'(1);
            else if (32'(wr_data) > MAX_COLS)
                cols_next = CSW'(MAX_COLS);
            else
                cols_next = CSW'(wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= RSW'(ROWS_RST);
            cols_reg <= CSW'(COLS_RST);
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    // Restart the walk on a size write or a load
    assign walk_cmd.restart = wr_en || load_req;
    assign walk_cmd.advance = next_req && !wr_en;

    somr_walk #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .RSW      (RSW),
        .CSW      (CSW)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (walk_cmd),
        .rows_size (rows_next),
        .cols_size (cols_next),
        .step_row  (step_row),
        .step_col  (step_col),
        .step_last (step_last)
    );

    // Drop loads that fall outside the store
    assign store_we = load_req && (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);
    assign wr_addr  = AW'(32'(row) * MAX_COLS + 32'(col));
    assign rd_addr  = AW'(32'(step_row) * MAX_COLS + 32'(step_col));

    // Fit the request value to the element width
    generate
        if (ELEMENT_BITS <= VALUE_BITS)
        begin : g_wr_narrow
            assign store_wdata = value[ELEMENT_BITS-1:0];
        end
        else
        begin : g_wr_wide
            assign store_wdata = ELEMENT_BITS'($unsigned(value));
        end
    endgenerate

    somr_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (wr_addr),
        .wr_data (store_wdata),
        .rd_en   (walk_cmd.advance),
        .rd_addr (rd_addr),
        .rd_data (store_rdata)
    );

    // Register the result position, flag and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= walk_cmd.advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_cmd.advance)
        begin
            at_row_reg <= POS_BITS'(step_row);
            at_col_reg <= POS_BITS'(step_col);
            last_reg   <= step_last;
        end
    end

    // Sign-extend or trim the stored element to the result width
    generate
        if (ELEMENT_BITS >= VALUE_BITS)
        begin : g_rd_wide
            assign element = $signed(store_rdata[VALUE_BITS-1:0]);
        end
        else
        begin : g_rd_narrow
            assign element = VALUE_BITS'($signed(store_rdata));
        end
    endgenerate

    assign done   = done_reg;
    assign at_row = at_row_reg;
    assign at_col = at_col_reg;
    assign last   = last_reg;

endmodule : spiral_order_matrix_reader
`default_nettype wire

// ===== rtl/somr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// somr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module somr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : somr_ram
`default_nettype wire

// ===== rtl/somr_walk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// somr_walk
// Spiral walk state: position, direction, shrinking bounds and count.
// Gives the position of the current step and whether it is the last one.
// ----------------------------------------------------------------------------
module somr_walk
    import somr_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int RSW      = $clog2(MAX_ROWS + 1),
    parameter int CSW      = $clog2(MAX_COLS + 1)
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire somr_walk_cmd_t cmd,
    input  wire logic [RSW-1:0] rows_size,
    input  wire logic [CSW-1:0] cols_size,
    output logic      [RSW-1:0] step_row,
    output logic      [CSW-1:0] step_col,
    output logic                step_last
);

    localparam int RW   = RSW + 1;
    localparam int CW   = CSW + 1;
    localparam int PW   = RSW + CSW;
    localparam int CNTW = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int ROWS_RST = (SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET;
    localparam int COLS_RST = (SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET;

    logic signed [RW-1:0] row_reg,    row_next;
    logic signed [CW-1:0] col_reg,    col_next;
    somr_dir_t            dir_reg,    dir_next;
    logic signed [RW-1:0] top_reg,    top_next;
    logic signed [RW-1:0] bottom_reg, bottom_next;
    logic signed [CW-1:0] left_reg,   left_next;
    logic signed [CW-1:0] right_reg,  right_next;
    logic [CNTW-1:0]      count_reg,  count_next;

    // Outcome of one advance
    logic signed [RW-1:0] adv_row, adv_top, adv_bottom;
    logic signed [CW-1:0] adv_col, adv_left, adv_right;
    somr_dir_t            adv_dir;
    logic                 adv_found;
    logic [CNTW-1:0]      adv_count;
    logic [PW-1:0]        size_prod;

    // Search at most four turns for the next in-bounds position
    always_comb
    begin
        logic signed [RW-1:0] nr;
        logic signed [CW-1:0] nc;
        logic                 in_bounds;
        adv_row    = row_reg;
        adv_col    = col_reg;
        adv_dir    = dir_reg;
        adv_top    = top_reg;
        adv_bottom = bottom_reg;
        adv_left   = left_reg;
        adv_right  = right_reg;
        adv_found  = 1'b0;
        for (int t = 0; t < 4; t++)
        begin
            nr = adv_row;
            nc = adv_col;
            case (adv_dir)
                DIR_DOWN:  nr = adv_row + RW'(1);
                DIR_RIGHT: nc = adv_col + CW'(1);
                DIR_UP:    nr = adv_row - RW'(1);
                default:   nc = adv_col - CW'(1);
            endcase
            if (adv_dir inside {DIR_DOWN, DIR_UP})
            begin
                in_bounds = (nr < adv_bottom) && (nr > adv_top);
            end
            else
            begin
                in_bounds = (nc < adv_right) && (nc > adv_left);
            end
            if (!adv_found)
            begin
                if (in_bounds)
                begin
                    adv_row   = nr;
                    adv_col   = nc;
                    adv_found = 1'b1;
                end
                else
                begin
                    case (adv_dir)
                        DIR_DOWN:  adv_bottom = adv_bottom - RW'(1);
                        DIR_RIGHT: adv_right  = adv_right - CW'(1);
                        DIR_UP:    adv_top    = adv_top + RW'(1);
                        default:   adv_left   = adv_left + CW'(1);
                    endcase
                    adv_dir = somr_dir_t'(2'(adv_dir + 2'd1));
                end
            end
        end
    end

    // Count this step and flag the last one
    assign adv_count = adv_found ? (count_reg + CNTW'(1)) : CNTW'(1);
    assign size_prod = PW'(rows_size) * PW'(cols_size);
    assign step_last = 32'(adv_count) >= 32'(size_prod);
    assign step_row  = adv_found ? RSW'(adv_row) : '0;
    assign step_col  = adv_found ? CSW'(adv_col) : '0;

    // Restart on command, advance on a next request, wrap after the last
    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        dir_next    = dir_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        count_next  = count_reg;
        if (cmd.restart || (cmd.advance && step_last))
        begin
            row_next    = '1;
            col_next    = '0;
            dir_next    = DIR_DOWN;
            top_next    = '1;
            bottom_next = $signed({1'b0, rows_size});
            left_next   = '0;
            right_next  = $signed({1'b0, cols_size});
            count_next  = '0;
        end
        else if (cmd.advance)
        begin
            count_next = adv_count;
            if (adv_found)
            begin
                row_next    = adv_row;
                col_next    = adv_col;
                dir_next    = adv_dir;
                top_next    = adv_top;
                bottom_next = adv_bottom;
                left_next   = adv_left;
                right_next  = adv_right;
            end
            else
            begin
                row_next    = '0;
                col_next    = '0;
                dir_next    = DIR_DOWN;
                top_next    = '1;
                bottom_next = $signed({1'b0, rows_size});
                left_next   = '0;
                right_next  = $signed({1'b0, cols_size});
            end
        end
    end

    // Hold walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '1;
            col_reg    <= '0;
            dir_reg    <= DIR_DOWN;
            top_reg    <= '1;
            bottom_reg <= RW'(ROWS_RST);
            left_reg   <= '0;
            right_reg  <= CW'(COLS_RST);
            count_reg  <= '0;
        end
        else
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            dir_reg    <= dir_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            count_reg  <= count_next;
        end
    end

endmodule : somr_walk
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the spiral order matrix reader. It drives load
// and next requests and size writes, keeps its own copy of the store and
// the walk, and compares every emitted element, position and last flag.
// ----------------------------------------------------------------------------
module testbench;
    import somr_pkg::*;

    localparam int STORE_ROWS    = MAX_ROWS_DEF;
    localparam int STORE_COLS    = MAX_COLS_DEF;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 3;
    localparam int RANDOM_ITEMS  = 1100;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] element;
        logic        [POS_BITS-1:0]   at_row;
        logic        [POS_BITS-1:0]   at_col;
        logic                         last;
    } spiral_elem_t;

    // Block ports
    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         start    = 1'b0;
    logic                         kind     = KIND_LOAD;
    logic        [POS_BITS-1:0]   row      = '0;
    logic        [POS_BITS-1:0]   col      = '0;
    logic signed [VALUE_BITS-1:0] value    = '0;
    logic                         wr_en    = 1'b0;
    logic        [IDX_BITS-1:0]   wr_index = REG_ROWS;
    logic        [CFG_BITS-1:0]   wr_data  = '0;
    logic                         busy;
    logic                         done;
    logic signed [VALUE_BITS-1:0] element;
    logic        [POS_BITS-1:0]   at_row;
    logic        [POS_BITS-1:0]   at_col;
    logic                         last;

    // Spiral walk mirror
    logic signed [VALUE_BITS-1:0] store_mem [STORE_ROWS*STORE_COLS];
    int        size_rows;
    int        size_cols;
    int        walk_row;
    int        walk_col;
    somr_dir_t walk_dir;
    int        top_b;
    int        bottom_b;
    int        left_b;
    int        right_b;
    int        emitted;

    spiral_elem_t pending_elements [$];

    // Bookkeeping
    bit idle_enabled = 1'b0;
    int n_loads      = 0;
    int n_nexts      = 0;
    int n_writes     = 0;
    int n_results    = 0;
    int n_fail       = 0;
    int idle_cycles  = 0;

    spiral_order_matrix_reader dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .row      (row),
        .col      (col),
        .value    (value),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .done     (done),
        .element  (element),
        .at_row   (at_row),
        .at_col   (at_col),
        .last     (last)
    );

    // Free-running clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_size(input int v, input int maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // Put the walk back at its start, just above the top-left corner
    function automatic void restart_walk();
        walk_row = -1;
        walk_col = 0;
        walk_dir = DIR_DOWN;
        top_b    = -1;
        bottom_b = size_rows;
        left_b   = 0;
        right_b  = size_cols;
        emitted  = 0;
    endfunction

    // Step the walk one position and return the element found there
    function automatic spiral_elem_t next_spiral_element();
        spiral_elem_t res;
        int           turn;
        int           nr;
        int           nc;
        bit           in_bounds;
        bit           found;
        found = 1'b0;
        for (turn = 0; turn < 4 && !found; turn++)
        begin
            nr = walk_row;
            nc = walk_col;
            case (walk_dir)
                DIR_DOWN:  nr++;
                DIR_RIGHT: nc++;
                DIR_UP:    nr--;
                default:   nc--;
            endcase
            if (walk_dir == DIR_DOWN || walk_dir == DIR_UP)
                in_bounds = nr < bottom_b && nr > top_b;
            else
                in_bounds = nc < right_b && nc > left_b;
            if (in_bounds)
            begin
                walk_row = nr;
                walk_col = nc;
                found    = 1'b1;
            end
            else
            begin
                // Close in the bound of the finished pass and turn
                case (walk_dir)
                    DIR_DOWN:  bottom_b--;
                    DIR_RIGHT: right_b--;
                    DIR_UP:    top_b++;
                    default:   left_b++;
                endcase
                walk_dir = walk_dir.next();
            end
        end
        if (!found)
        begin
            restart_walk();
            walk_row = 0;
            walk_col = 0;
        end
        emitted++;
        if (walk_row >= 0 && walk_col >= 0 && walk_row < STORE_ROWS && walk_col < STORE_COLS)
            res.element = store_mem[walk_row*STORE_COLS + walk_col];
        else
            res.element = '0;
        res.at_row = walk_row[POS_BITS-1:0];
        res.at_col = walk_col[POS_BITS-1:0];
        res.last   = emitted >= size_rows*size_cols;
        if (res.last)
            restart_walk();
        return res;
    endfunction

    // Pick a gap: mostly none or short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!idle_enabled || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Pick a size register value: mostly small, some large, a few out of range
    function automatic logic [CFG_BITS-1:0] random_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75)
            return CFG_BITS'($urandom_range(1, 5));
        if (p < 93)
            return CFG_BITS'($urandom_range(6, 16));
        if (p < 96)
            return '0;
        return CFG_BITS'($urandom_range(17, 31));
    endfunction

    // Hold one request until it is taken, update the mirror, then idle for a random gap, if any
    task automatic send_request(input logic k, input logic [POS_BITS-1:0] r,
                                input logic [POS_BITS-1:0] c,
                                input logic signed [VALUE_BITS-1:0] v);
        int gap;
        start <= 1'b1;
        kind  <= k;
        row   <= r;
        col   <= c;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (k == KIND_NEXT)
        begin
            n_nexts++;
            pending_elements.push_back(next_spiral_element());
        end
        else
        begin
            n_loads++;
            store_mem[r*STORE_COLS + c] = v;
            restart_walk();
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Next request with random content in the unused fields
    task automatic send_next();
        send_request(KIND_NEXT, POS_BITS'($urandom_range(0, 15)),
                     POS_BITS'($urandom_range(0, 15)),
                     VALUE_BITS'($urandom_range(0, 65535)));
    endtask

    // Write a size register once the block has drained
    task automatic write_size(input logic [IDX_BITS-1:0] idx,
                              input logic [CFG_BITS-1:0] data);
        start <= 1'b0;
        while (pending_elements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        n_writes++;
        if (idx == REG_ROWS)
            size_rows = clamp_size(int'(data), STORE_ROWS);
        else
            size_cols = clamp_size(int'(data), STORE_COLS);
        restart_walk();
    endtask

    // Reset size: fill 3x3, walk part way, restart by a load, walk and wrap
    task automatic test_reset_spiral();
        int r;
        int c;
        logic signed [VALUE_BITS-1:0] v;
        idle_enabled = 1'b0;
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < 3; c++)
            begin
                v = VALUE_BITS'((r*3 + c)*1000 - 4000);
                if (r == 0 && c == 0)
                    v = 16'sh8000;
                else if (r == 2 && c == 2)
                    v = 16'sh7FFF;
                else if (r == 1 && c == 1)
                    v = -16'sd1;
                send_request(KIND_LOAD, POS_BITS'(r), POS_BITS'(c), v);
            end
        end
        // Stored outside the 3x3 area, not visited yet
        send_request(KIND_LOAD, 4'd15, 4'd15, 16'sh5A5A);
        repeat (4) send_next();
        send_request(KIND_LOAD, 4'd1, 4'd1, 16'sd0);
        repeat (11) send_next();
    endtask

    // Load the whole store so that any size reads only written elements
    task automatic test_fill_store();
        int idx;
        idle_enabled = 1'b1;
        for (idx = 0; idx < STORE_ROWS*STORE_COLS; idx++)
            send_request(KIND_LOAD, POS_BITS'(idx / STORE_COLS), POS_BITS'(idx % STORE_COLS),
                         VALUE_BITS'($urandom_range(0, 65535)));
    endtask

    // Walk full spirals at the corner sizes, out of range values included
    task automatic test_size_extremes();
        int rows_list [7] = '{0, 1, 16, 31, 2, 16, 5};
        int cols_list [7] = '{0, 16, 1, 2, 17, 16, 7};
        int i;
        for (i = 0; i < 7; i++)
        begin
            write_size(REG_ROWS, CFG_BITS'(rows_list[i]));
            write_size(REG_COLS, CFG_BITS'(cols_list[i]));
            repeat (size_rows*size_cols + 2) send_next();
        end
        // Size write in the middle of a walk restarts it
        write_size(REG_ROWS, 5'd4);
        repeat (5) send_next();
        write_size(REG_COLS, 5'd4);
        repeat (17) send_next();
    endtask

    // Let every result come out before sending more
    task automatic test_drain_pause();
        idle_enabled = 1'b0;
        repeat (6) send_next();
        start <= 1'b0;
        while (pending_elements.size() != 0)
            @(posedge clk);
        idle_enabled = 1'b1;
        repeat (10) send_next();
    endtask

    // Runs of next requests over random sizes, with a few stray loads
    task automatic test_random();
        int sent;
        int run_len;
        int pick;
        int k;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                write_size(REG_ROWS, random_size());
            else if (pick < 4)
                write_size(REG_COLS, random_size());
            idle_enabled = $urandom_range(0, 3) != 0;
            run_len = $urandom_range(1, 2*size_rows*size_cols + 2);
            if (run_len > 300)
                run_len = 300;
            for (k = 0; k < run_len; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_request(KIND_LOAD, POS_BITS'($urandom_range(0, 15)),
                                 POS_BITS'($urandom_range(0, 15)),
                                 VALUE_BITS'($urandom_range(0, 65535)));
                else
                    send_next();
                sent++;
            end
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic signed [VALUE_BITS:0] want_v,
                                        input logic signed [VALUE_BITS:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            n_fail++;
        end
    endfunction

    // Compare each strobed result with the oldest expected element
    always @(posedge clk)
    begin : check_results
        spiral_elem_t want;
        if (rst_n && done)
        begin
            if (pending_elements.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d at (%0d,%0d)",
                         $time, element, at_row, at_col);
                n_fail++;
            end
            else
            begin
                want = pending_elements.pop_front();
                n_results++;
                check_field("element", (VALUE_BITS+1)'(want.element),
                            (VALUE_BITS+1)'(element));
                check_field("at_row", (VALUE_BITS+1)'(want.at_row), (VALUE_BITS+1)'(at_row));
                check_field("at_col", (VALUE_BITS+1)'(want.at_col), (VALUE_BITS+1)'(at_col));
                check_field("last", (VALUE_BITS+1)'(want.last), (VALUE_BITS+1)'(last));
            end
        end
    end

    // Drop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout after %0d idle cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_elements.size());
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        size_rows = SIZE_RESET;
        size_cols = SIZE_RESET;
        foreach (store_mem[i])
            store_mem[i] = '0;
        restart_walk();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_spiral();
        test_fill_store();
        test_size_extremes();
        test_drain_pause();
        test_random();

        // Drain and settle
        start <= 1'b0;
        while (pending_elements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d loads and %0d next requests over %0d size writes",
                 n_loads, n_nexts, n_writes);
        $display("Checked %0d spiral elements, %0d mismatches", n_results, n_fail);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
